// ===== hw/rtl/rndset_pkg.sv =====
`default_nettype none

package rndset_pkg;

	localparam int CAPACITY = 256;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int RSP_CNT_W = 9;

	localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_SAMPLE = 2'd2;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic                 success;
		logic signed [31:0]   sample_value;
		logic [RSP_CNT_W-1:0] element_count;
	} rsp_t;

	typedef enum logic [1:0] {
		RD_SRCH,
		RD_LAST,
		RD_SMP
	} rd_sel_t;

	typedef enum logic {
		WR_APPEND,
		WR_MOVE
	} wr_sel_t;

	typedef struct packed {
		logic    load_req;
		logic    srch_run;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    lfsr_adv;
		logic    mul_en;
		logic    res_load;
		logic    res_ok;
		logic    res_sample;
	} cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic cnt_full;
		logic srch_done;
		logic srch_hit;
		logic out_free;
	} sts_t;

	function automatic logic [31:0] lfsr_next(input logic [31:0] s);
		logic [31:0] n;
		n = {1'b0, s[31:1]};
		if (s[0]) begin
			n = n ^ LFSR_MASK;
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rndset_ctrl.sv =====
`default_nettype none

module rndset_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire logic [1:0]        req_type,
	output      logic              req_stall,
	input  wire rndset_pkg::sts_t  sts,
	output      rndset_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_INS_WR,
		ST_MOVE_RD,
		ST_MOVE_WR,
		ST_SMP_STEP,
		ST_SMP_MUL,
		ST_SMP_RD,
		ST_RESP
	} state_t;

	state_t     state_q;
	logic [1:0] op_q;
	logic       ok_q;

	assign req_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= rndset_pkg::REQ_INSERT;
			ok_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						op_q <= req_type;
						ok_q <= 1'b0;
						case (req_type)
							rndset_pkg::REQ_INSERT:
								state_q <= sts.cnt_full ? ST_RESP : ST_SEARCH;
							rndset_pkg::REQ_REMOVE:
								state_q <= ST_SEARCH;
							rndset_pkg::REQ_SAMPLE:
								state_q <= sts.cnt_zero ? ST_RESP : ST_SMP_STEP;
							default:
								state_q <= ST_RESP;
						endcase
					end
				end
				ST_SEARCH: begin
					if (sts.srch_done) begin
						if (op_q == rndset_pkg::REQ_INSERT) begin
							state_q <= sts.srch_hit ? ST_RESP : ST_INS_WR;
						end else begin
							state_q <= sts.srch_hit ? ST_MOVE_RD : ST_RESP;
						end
					end
				end
				ST_INS_WR: begin
					ok_q    <= 1'b1;
					state_q <= ST_RESP;
				end
				ST_MOVE_RD: begin
					state_q <= ST_MOVE_WR;
				end
				ST_MOVE_WR: begin
					ok_q    <= 1'b1;
					state_q <= ST_RESP;
				end
				ST_SMP_STEP: begin
					state_q <= ST_SMP_MUL;
				end
				ST_SMP_MUL: begin
					state_q <= ST_SMP_RD;
				end
				ST_SMP_RD: begin
					ok_q    <= 1'b1;
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.rd_sel     = rndset_pkg::RD_SRCH;
		cmd.wr_sel     = rndset_pkg::WR_APPEND;
		cmd.res_ok     = ok_q;
		cmd.res_sample = ok_q && (op_q == rndset_pkg::REQ_SAMPLE);
		unique case (state_q)
			ST_IDLE: begin
				cmd.load_req = req_valid;
			end
			ST_SEARCH: begin
				cmd.srch_run = 1'b1;
				cmd.rd_en    = 1'b1;
			end
			ST_INS_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			ST_MOVE_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = rndset_pkg::RD_LAST;
			end
			ST_MOVE_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = rndset_pkg::WR_MOVE;
				cmd.cnt_dec = 1'b1;
			end
			ST_SMP_STEP: begin
				cmd.lfsr_adv = 1'b1;
			end
			ST_SMP_MUL: begin
				cmd.mul_en = 1'b1;
			end
			ST_SMP_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = rndset_pkg::RD_SMP;
			end
			ST_RESP: begin
				cmd.res_load = sts.out_free;
			end
			default: begin
				cmd.load_req = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rndset_dp.sv =====
`default_nettype none

module rndset_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rndset_pkg::req_t  req,
	input  wire logic              cfg_we,
	input  wire logic [31:0]       cfg_wdata,
	input  wire rndset_pkg::cmd_t  cmd,
	output      rndset_pkg::sts_t  sts,
	output      logic              rsp_valid,
	input  wire logic              rsp_stall,
	output      rndset_pkg::rsp_t  rsp
);

	localparam int IDX_W  = rndset_pkg::IDX_W;
	localparam int CNT_W  = rndset_pkg::CNT_W;
	localparam int PROD_W = 32 + CNT_W;

	logic [31:0]       mem_q [rndset_pkg::CAPACITY];
	logic [31:0]       value_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  ptr_q;
	logic              cmp_vld_q;
	logic [IDX_W-1:0]  cmp_idx_q;
	logic              hit_q;
	logic [IDX_W-1:0]  slot_q;
	logic [31:0]       rd_data_q;
	logic [31:0]       lfsr_q;
	logic [PROD_W-1:0] prod_q;
	logic              rsp_valid_q;
	rndset_pkg::rsp_t  rsp_q;

	logic [IDX_W-1:0]  rd_addr;
	logic [IDX_W-1:0]  wr_addr;
	logic [31:0]       wr_data;
	logic [CNT_W-1:0]  last_idx;

	assign last_idx = cnt_q - CNT_W'(1);

	always_comb begin
		case (cmd.rd_sel)
			rndset_pkg::RD_LAST: rd_addr = last_idx[IDX_W-1:0];
			rndset_pkg::RD_SMP:  rd_addr = prod_q[32 +: IDX_W];
			default:             rd_addr = ptr_q[IDX_W-1:0];
		endcase
		if (cmd.wr_sel == rndset_pkg::WR_MOVE) begin
			wr_addr = slot_q;
			wr_data = rd_data_q;
		end else begin
			wr_addr = cnt_q[IDX_W-1:0];
			wr_data = value_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			value_q <= req.value;
		end
		if (cmd.mul_en) begin
			prod_q <= PROD_W'(lfsr_q) * PROD_W'(cnt_q);
		end
		if (cmd.res_load) begin
			rsp_q.success       <= cmd.res_ok;
			rsp_q.sample_value  <= cmd.res_sample ? rd_data_q : 32'd0;
			rsp_q.element_count <= rndset_pkg::RSP_CNT_W'(cnt_q);
		end
	end

	// search streams one entry per cycle: address goes out, compare in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ptr_q       <= '0;
			cmp_vld_q   <= 1'b0;
			cmp_idx_q   <= '0;
			hit_q       <= 1'b0;
			slot_q      <= '0;
			lfsr_q      <= 32'd1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load_req) begin
				ptr_q     <= '0;
				cmp_vld_q <= 1'b0;
				hit_q     <= 1'b0;
			end else if (cmd.srch_run) begin
				if (!hit_q && cmp_vld_q && (rd_data_q == value_q)) begin
					hit_q  <= 1'b1;
					slot_q <= cmp_idx_q;
				end
				if (ptr_q < cnt_q) begin
					cmp_vld_q <= 1'b1;
					cmp_idx_q <= ptr_q[IDX_W-1:0];
					ptr_q     <= ptr_q + CNT_W'(1);
				end else begin
					cmp_vld_q <= 1'b0;
				end
			end

			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= last_idx;
			end

			if (cfg_we) begin
				lfsr_q <= (cfg_wdata == 32'd0) ? 32'd1 : cfg_wdata;
			end else if (cmd.lfsr_adv) begin
				lfsr_q <= rndset_pkg::lfsr_next(lfsr_q);
			end

			if (cmd.res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.cnt_zero  = (cnt_q == '0);
		sts.cnt_full  = (cnt_q >= CNT_W'(rndset_pkg::CAPACITY));
		sts.srch_done = hit_q || (!cmp_vld_q && (ptr_q >= cnt_q));
		sts.srch_hit  = hit_q;
		sts.out_free  = !rsp_valid_q || !rsp_stall;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ===== hw/rtl/randomized_set_table.sv =====
// channel | signals                          | beat moves
// req     | req_valid, req_stall, req        | req_type, value
// rsp     | rsp_valid, rsp_stall, rsp        | success, sample_value, element_count
// cfg     | cfg_we, cfg_wdata                | rng_seed, no handshake
//
// Insert/remove: linear search of the live entries, one entry per cycle; a full
// store rejects an insert without a search. Sample: LFSR step, 32x9 multiply,
// memory read, response. Reset clears count and loads the generator with 1;
// memory is not cleared. A stalled response sits in the output register; the
// next request is taken meanwhile and waits only at its own response.
`default_nettype none

module randomized_set_table (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output      logic              req_stall,
	input  wire rndset_pkg::req_t  req,
	output      logic              rsp_valid,
	input  wire logic              rsp_stall,
	output      rndset_pkg::rsp_t  rsp,
	input  wire logic              cfg_we,
	input  wire logic [31:0]       cfg_wdata
);

	rndset_pkg::cmd_t cmd;
	rndset_pkg::sts_t sts;

	rndset_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rndset_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/rndset_chk.sv =====
`default_nettype none

module rndset_chk (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             req_valid,
	input wire logic             req_stall,
	input wire rndset_pkg::req_t req,
	input wire logic             rsp_valid,
	input wire logic             rsp_stall,
	input wire rndset_pkg::rsp_t rsp,
	input wire logic             cfg_we,
	input wire logic [31:0]      cfg_wdata
);

	// one request in flight: the port closes right after a beat
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request port still open after a beat");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled response changed");

	a_fail_no_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.success) |-> (rsp.sample_value == 32'sd0))
		else $error("failed request carries a sample");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.element_count <= 9'(rndset_pkg::CAPACITY)))
		else $error("element count beyond capacity");

endmodule

bind randomized_set_table rndset_chk u_chk (.*);

`default_nettype wire

// ===== bench/randomized_set_table_tb.sv =====
`timescale 1ns / 100ps

module randomized_set_table_tb;
	import rndset_pkg::*;

	localparam logic [1:0]  REQ_UNUSED   = 2'd3;
	localparam int unsigned LIMIT_CYCLES = 4_000_000;
	localparam int          DRAIN_CYCLES = CAPACITY + 16;
	localparam int          MAX_SHOWN    = 10;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_stall;
	rsp_t        rsp;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	randomized_set_table u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// shadow copy of the set, its count and the sampling generator
	logic [31:0] set_mem [CAPACITY];
	int unsigned set_cnt;
	logic [31:0] lfsr_q;
	rsp_t        pending_rsp[$];
	int          err_cnt = 0;

	// traffic shaping knobs
	int          gap_max       = 0;
	int          burst_max     = 1;
	int          burst_left    = 0;
	int          stall_pct     = 0;
	int          stall_run_max = 1;
	int          hold_len      = 0;
	logic [31:0] val_pool[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned find_member(input logic [31:0] v);
		for (int unsigned i = 0; i < set_cnt; i++) begin
			if (set_mem[i] == v) begin
				return i;
			end
		end
		return set_cnt;
	endfunction

	function automatic rsp_t predict_set_op(input req_t r);
		rsp_t        o;
		int unsigned slot;
		logic [63:0] prod;
		int unsigned pick;
		o = '0;
		case (r.req_type)
			REQ_INSERT: begin
				if (set_cnt < CAPACITY && find_member(r.value) == set_cnt) begin
					set_mem[set_cnt] = r.value;
					set_cnt++;
					o.success = 1'b1;
				end
			end
			REQ_REMOVE: begin
				slot = find_member(r.value);
				if (slot < set_cnt) begin
					// last live entry fills the hole
					set_mem[slot] = set_mem[set_cnt - 1];
					set_cnt--;
					o.success = 1'b1;
				end
			end
			REQ_SAMPLE: begin
				if (set_cnt != 0) begin
					lfsr_q = {1'b0, lfsr_q[31:1]} ^ (lfsr_q[0] ? LFSR_MASK : 32'h0);
					prod = 64'(lfsr_q) * 64'(set_cnt);
					pick = prod[63:32];
					if (pick >= set_cnt) begin
						pick = set_cnt - 1;
					end
					o.sample_value = set_mem[pick];
					o.success = 1'b1;
				end
			end
			default: ;
		endcase
		o.element_count = 9'(set_cnt);
		return o;
	endfunction

	task automatic set_idle(input int gap, input int burst, input int pct, input int run);
		gap_max = gap;
		burst_max = burst;
		stall_pct = pct;
		stall_run_max = run;
		burst_left = 0;
	endtask

	// one request beat; returns at the edge that accepted it
	task automatic send_req(input logic [1:0] op, input logic [31:0] val);
		req_t item;
		rsp_t exp_rsp;
		int   gap;
		item.req_type = op;
		item.value = val;
		if (burst_left <= 0) begin
			gap = $urandom_range(gap_max, 0);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(burst_max, 1);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
		exp_rsp = predict_set_op(item);
		pending_rsp = {pending_rsp, exp_rsp};
		burst_left--;
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_seed(input logic [31:0] s);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= s;
		@(posedge clk);
		cfg_we <= 1'b0;
		lfsr_q = (s == 32'h0) ? 32'h1 : s;
	endtask

	function automatic logic [31:0] pool_value();
		if ($urandom_range(9) == 0 || val_pool.size() == 0) begin
			return $urandom;
		end
		return val_pool[$urandom_range(val_pool.size() - 1)];
	endfunction

	task automatic test_directed();
		set_idle(3, 4, 30, 3);
		send_req(REQ_SAMPLE, 32'h0);          // empty set
		send_req(REQ_REMOVE, 32'h5);          // absent
		send_req(REQ_INSERT, 32'h8000_0000);
		send_req(REQ_INSERT, 32'h7FFF_FFFF);
		send_req(REQ_INSERT, 32'h0);
		send_req(REQ_INSERT, 32'hFFFF_FFFF);
		send_req(REQ_INSERT, 32'h5555_5555);
		send_req(REQ_INSERT, 32'hAAAA_AAAA);
		send_req(REQ_INSERT, 32'h7FFF_FFFF);  // duplicate
		send_req(REQ_SAMPLE, $urandom);
		send_req(REQ_SAMPLE, $urandom);
		send_req(REQ_SAMPLE, $urandom);
		send_req(REQ_REMOVE, 32'h0);          // middle slot, tail moves in
		send_req(REQ_REMOVE, 32'hAAAA_AAAA);
		send_req(REQ_REMOVE, 32'h0);          // already gone
		send_req(REQ_UNUSED, 32'h1234_5678);
		send_req(REQ_SAMPLE, 32'hFFFF_FFFF);
		send_req(REQ_REMOVE, 32'h8000_0000);
		send_req(REQ_REMOVE, 32'h7FFF_FFFF);
		send_req(REQ_REMOVE, 32'hFFFF_FFFF);
		send_req(REQ_REMOVE, 32'h5555_5555);
		send_req(REQ_SAMPLE, 32'h0);
		send_req(REQ_UNUSED, 32'hFFFF_FFFF);
	endtask

	task automatic test_seeds();
		logic [31:0] seeds [5];
		seeds = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000, $urandom | 32'h1};
		set_idle(0, 1, 0, 1);
		for (int i = 0; i < 7; i++) begin
			send_req(REQ_INSERT, $urandom);
		end
		foreach (seeds[i]) begin
			write_seed(seeds[i]);
			repeat (4) send_req(REQ_SAMPLE, $urandom);
		end
		while (set_cnt != 0) begin
			send_req(REQ_REMOVE, set_mem[0]);
		end
	endtask

	task automatic test_fill_to_capacity();
		write_seed($urandom);
		set_idle(2, 16, 20, 4);
		while (set_cnt < CAPACITY) begin
			send_req(REQ_INSERT, $urandom);
			if ($urandom_range(15) == 0) begin
				send_req(REQ_SAMPLE, $urandom);
			end
		end
		send_req(REQ_INSERT, $urandom);            // full, new value
		send_req(REQ_INSERT, set_mem[CAPACITY-1]); // full, present value
		repeat (4) send_req(REQ_SAMPLE, $urandom);
		while (set_cnt != 0) begin
			case ($urandom_range(9))
				0:       send_req(REQ_SAMPLE, $urandom);
				1:       send_req(REQ_REMOVE, $urandom);
				default: send_req(REQ_REMOVE, set_mem[$urandom_range(set_cnt - 1)]);
			endcase
		end
	endtask

	task automatic test_random_traffic();
		int pool_sz [4];
		int gaps    [4];
		int bursts  [4];
		int pcts    [4];
		int runs    [4];
		int pick;
		pool_sz = '{12, 48, 300, 24};
		gaps    = '{0, 6, 2, 10};
		bursts  = '{1, 8, 20, 3};
		pcts    = '{0, 40, 70, 20};
		runs    = '{1, 6, 12, 2};
		for (int ph = 0; ph < 4; ph++) begin
			write_seed($urandom);
			set_idle(gaps[ph], bursts[ph], pcts[ph], runs[ph]);
			val_pool.delete();
			for (int i = 0; i < pool_sz[ph]; i++) begin
				case ($urandom_range(7))
					0:       val_pool = {val_pool, 32'h8000_0000};
					1:       val_pool = {val_pool, 32'h7FFF_FFFF};
					default: val_pool = {val_pool, 32'($urandom)};
				endcase
			end
			for (int n = 0; n < 225; n++) begin
				pick = $urandom_range(99);
				if (pick < 45) begin
					send_req(REQ_INSERT, pool_value());
				end else if (pick < 75) begin
					send_req(REQ_REMOVE, pool_value());
				end else if (pick < 96) begin
					send_req(REQ_SAMPLE, $urandom);
				end else begin
					send_req(REQ_UNUSED, $urandom);
				end
			end
		end
	endtask

	// long response hold-off while requests keep being offered
	task automatic test_backpressure();
		set_idle(0, 1, 0, 1);
		hold_len = 300;
		for (int n = 0; n < 40; n++) begin
			case ($urandom_range(2))
				0:       send_req(REQ_INSERT, pool_value());
				1:       send_req(REQ_REMOVE, pool_value());
				default: send_req(REQ_SAMPLE, $urandom);
			endcase
		end
	endtask

	// receiver stall in runs of random length
	initial begin
		int   run_left;
		logic lvl;
		run_left = 0;
		lvl = 1'b0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
				run_left = 0;
			end else begin
				if (run_left <= 0) begin
					lvl = ($urandom_range(99) < stall_pct);
					run_left = $urandom_range(stall_run_max, 1);
				end
				run_left--;
				rsp_stall <= lvl;
			end
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_SHOWN) begin
					$display("unexpected response at %0t: ok=%0b val=%h cnt=%0d", $time,
						rsp.success, rsp.sample_value, rsp.element_count);
				end
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.success !== want.success || rsp.sample_value !== want.sample_value ||
						rsp.element_count !== want.element_count) begin
					err_cnt++;
					if (err_cnt <= MAX_SHOWN) begin
						$display("mismatch at %0t: exp %0b %h %0d, got %0b %h %0d",
							$time, want.success, want.sample_value, want.element_count,
							rsp.success, rsp.sample_value, rsp.element_count);
					end
				end
			end
		end
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		set_cnt = 0;
		lfsr_q = 32'h1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_seeds();
		test_fill_to_capacity();
		test_random_traffic();
		test_backpressure();
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		err_cnt += pending_rsp.size();
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
